@@ rtl/itoa_pkg.sv @@
`default_nettype none

package itoa_pkg;

    // Default cap on the field width; the text never exceeds it.
    localparam int DEFAULT_MAX_WIDTH = 64;

    // Conversion modes.
    localparam logic [2:0] MODE_BIN  = 3'd0;
    localparam logic [2:0] MODE_HEX  = 3'd1;
    localparam logic [2:0] MODE_PTR  = 3'd2;
    localparam logic [2:0] MODE_UDEC = 3'd3;
    localparam logic [2:0] MODE_SDEC = 3'd4;

    // Radix codes held while the digits are produced.
    localparam logic [1:0] BASE_2  = 2'd0;
    localparam logic [1:0] BASE_16 = 2'd1;
    localparam logic [1:0] BASE_10 = 2'd2;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_X = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // ceil(2^35 / 10): floor(n * RECIP10 / 2^35) == n / 10 for every 32-bit n.
    localparam logic [31:0] RECIP10 = 32'hcccc_cccd;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] value;
        logic        zero_fill;
        logic        alt_prefix;
        logic [7:0]  field_width;
    } t_in_word;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
        logic       error;
    } t_out_word;

    // Lowercase ASCII for one digit of value 0 to 15.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'b0, d};
        end else begin
            c = CH_LOW_A + {4'b0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/integer_to_ascii_formatter.sv @@
`default_nettype none

// Integer to ASCII formatter, printf style (%b, %x, %p, %u, %d).
// Input channel: one word per number (mode, value, zero_fill, alt_prefix,
// field_width), taken on i_in_valid & o_in_ready. Output channel: one word
// per character, leftmost character first, with last set on the final one.
// A pointer request with zero padding, or an unused mode, gives a single
// word with error and last set and a zero character.
// The block works on one number at a time and is not ready while it does.
// It first builds the text in a character buffer with one write port, from
// the digits (a decimal digit needs a multiply by the reciprocal of ten,
// then a correction), then the zero padding, the prefix letter and zero,
// the sign and the space padding. It then reads the buffer back, one
// character per cycle while the receiver does not stall.
// A finished output word waits in an output register; when the receiver
// stalls, reads stop and nothing is lost. The next number is accepted while
// the final character still waits there.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register; the buffer contents are not cleared.
module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output t_out_word      o_out_word
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    // Sequencer codes.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIG  = 4'd3;
    localparam logic [3:0] S_ZPAD = 4'd4;
    localparam logic [3:0] S_PFXL = 4'd5;
    localparam logic [3:0] S_PFX0 = 4'd6;
    localparam logic [3:0] S_SIGN = 4'd7;
    localparam logic [3:0] S_SPC  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [31:0]   r_num, n_num;
    logic [28:0]   r_quo, n_quo;
    logic [1:0]    r_base, n_base;
    logic          r_zpad, n_zpad;
    logic          r_alt, n_alt;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_tgt, n_tgt;
    logic [CW-1:0] r_len, n_len;
    logic [CW-1:0] r_rem, n_rem;
    logic          r_pend, n_pend;
    logic          r_pend_last, n_pend_last;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out, n_out;
    logic [7:0]    r_rd_data;

    // Character buffer: one write port, one registered read port.
    logic [7:0] char_buffer [MAX_WIDTH];

    logic          w_acc;
    logic          w_err;
    logic          w_neg;
    logic          w_alt;
    logic [CW-1:0] w_cap;
    logic [1:0]    w_rsv;
    logic [CW-1:0] w_ztgt;
    logic [63:0]   w_prod;
    logic [3:0]    w_digit;
    logic [31:0]   w_q;
    logic          w_put;
    logic [7:0]    w_char;
    logic          w_room;
    logic          w_we;
    logic          w_load;
    logic          w_issue;
    logic [CW-1:0] w_rm1;
    logic [AW-1:0] w_raddr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_acc = i_in_valid && o_in_ready;
    assign w_err = (i_in_word.mode > MODE_SDEC)
                || ((i_in_word.mode == MODE_PTR) && i_in_word.zero_fill);
    assign w_neg = (i_in_word.mode == MODE_SDEC) && i_in_word.value[31];
    assign w_alt = i_in_word.alt_prefix || (i_in_word.mode == MODE_PTR);

    // Cap the width, then take out room for the prefix and sign when zero
    // padding, saturating at zero.
    always_comb begin
        if ({1'b0, i_in_word.field_width} > 9'(MAX_WIDTH)) begin
            w_cap = CW'(MAX_WIDTH);
        end else begin
            w_cap = CW'(i_in_word.field_width);
        end
        w_rsv = {w_alt, 1'b0} + {1'b0, w_neg};
        if (w_cap >= CW'(w_rsv)) begin
            w_ztgt = w_cap - CW'(w_rsv);
        end else begin
            w_ztgt = '0;
        end
    end

    // Shared digit unit: one digit and the quotient per step.
    assign w_prod = {32'b0, r_num} * {32'b0, RECIP10};

    always_comb begin
        unique case (r_base)
            BASE_2: begin
                w_digit = {3'b0, r_num[0]};
                w_q     = {1'b0, r_num[31:1]};
            end
            BASE_16: begin
                w_digit = r_num[3:0];
                w_q     = {4'b0, r_num[31:4]};
            end
            BASE_10: begin
                // The remainder is below ten, so four bits of the
                // difference are enough.
                w_digit = 4'(r_num[3:0] - 4'(r_quo[3:0] * 4'd10));
                w_q     = {3'b0, r_quo};
            end
            default: begin
                w_digit = '0;
                w_q     = '0;
            end
        endcase
    end

    assign w_room  = (r_len != CW'(MAX_WIDTH));
    assign w_we    = w_put && w_room;
    assign w_load  = r_pend && (!r_out_valid || i_out_ready);
    assign w_issue = (r_state == S_EMIT) && (r_rem != '0) && (!r_pend || w_load);
    assign w_rm1   = r_rem - CW'(1);
    assign w_raddr = w_rm1[AW-1:0];

    always_comb begin
        n_state     = r_state;
        n_num       = r_num;
        n_quo       = r_quo;
        n_base      = r_base;
        n_zpad      = r_zpad;
        n_alt       = r_alt;
        n_neg       = r_neg;
        n_tgt       = r_tgt;
        n_len       = r_len;
        n_rem       = r_rem;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_put       = 1'b0;
        w_char      = CH_SPACE;

        // Output register: refill from the buffer read, or drain.
        if (w_load) begin
            n_out_valid = 1'b1;
            n_out       = '{character: r_rd_data, last: r_pend_last, error: 1'b0};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (w_issue) begin
            n_pend      = 1'b1;
            n_pend_last = (r_rem == CW'(1));
            n_rem       = w_rm1;
        end else if (w_load) begin
            n_pend = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_len  = '0;
                    n_zpad = i_in_word.zero_fill;
                    n_alt  = w_alt;
                    n_neg  = w_neg;
                    n_tgt  = i_in_word.zero_fill ? w_ztgt : w_cap;
                    n_num  = w_neg ? (~i_in_word.value + 32'd1) : i_in_word.value;
                    if (i_in_word.mode == MODE_BIN) begin
                        n_base = BASE_2;
                    end else if ((i_in_word.mode == MODE_HEX)
                              || (i_in_word.mode == MODE_PTR)) begin
                        n_base = BASE_16;
                    end else begin
                        n_base = BASE_10;
                    end
                    if (w_err) begin
                        n_state = S_ERR;
                    end else if ((i_in_word.mode == MODE_UDEC)
                              || (i_in_word.mode == MODE_SDEC)) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_DIG;
                    end
                end
            end
            S_ERR: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = '{character: 8'h00, last: 1'b1, error: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_MUL: begin
                n_quo   = w_prod[63:35];
                n_state = S_DIG;
            end
            S_DIG: begin
                w_put  = 1'b1;
                w_char = digit_char(w_digit);
                n_num  = w_q;
                if (w_q == '0) begin
                    n_state = S_ZPAD;
                end else if (r_base == BASE_10) begin
                    n_state = S_MUL;
                end
            end
            S_ZPAD: begin
                if (r_zpad && (r_len < r_tgt)) begin
                    w_put  = 1'b1;
                    w_char = CH_ZERO;
                end else begin
                    n_state = S_PFXL;
                end
            end
            S_PFXL: begin
                // Buffer is filled right to left, so the letter goes first.
                if (r_alt && (r_base != BASE_10)) begin
                    w_put  = 1'b1;
                    w_char = (r_base == BASE_16) ? CH_LOW_X : CH_LOW_B;
                end
                n_state = S_PFX0;
            end
            S_PFX0: begin
                if (r_alt) begin
                    w_put  = 1'b1;
                    w_char = CH_ZERO;
                end
                n_state = S_SIGN;
            end
            S_SIGN: begin
                if (r_neg) begin
                    w_put  = 1'b1;
                    w_char = CH_MINUS;
                end
                n_state = S_SPC;
            end
            S_SPC: begin
                if (!r_zpad && (r_len < r_tgt)) begin
                    w_put  = 1'b1;
                    w_char = CH_SPACE;
                end else begin
                    n_rem   = r_len;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if ((r_rem == '0) && !r_pend) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_we) begin
            n_len = r_len + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_rem       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_rem       <= n_rem;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num       <= n_num;
        r_quo       <= n_quo;
        r_base      <= n_base;
        r_zpad      <= n_zpad;
        r_alt       <= n_alt;
        r_neg       <= n_neg;
        r_tgt       <= n_tgt;
        r_pend_last <= n_pend_last;
        r_out       <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            char_buffer[r_len[AW-1:0]] <= w_char;
        end
        if (w_issue) begin
            r_rd_data <= char_buffer[w_raddr];
        end
    end

`ifndef SYNTHESIS
    a_pend_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_EMIT))
        else $error("buffer read outstanding outside the emit phase");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= CW'(MAX_WIDTH))
        else $error("text length exceeds the buffer");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.error) |->
            (o_out_word.last && (o_out_word.character == 8'h00)))
        else $error("error word must be a single zero character");

    a_dec_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_err && ((i_in_word.mode == MODE_UDEC)
            || (i_in_word.mode == MODE_SDEC))) |=> (r_state == S_MUL))
        else $error("decimal number did not start with a multiply step");

    a_emit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SPC) && (n_state == S_EMIT)) |=> (r_rem != '0))
        else $error("empty text reached the emit phase");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none

// Self-checking bench for the integer to ASCII formatter.
//
// Every number word handed to the block is run through a behavioral formatter
// in this module the moment it is accepted. That formatter queues the
// character words the block should produce. A monitor pops one expected word
// per accepted output word and compares character, last and error.
module tb_top;
    import itoa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Highest mode the three mode bits can encode. Everything above
    // MODE_SDEC is unused and must come back as a single error word.
    localparam logic [2:0] MODE_TOP = 3'd7;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 200;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_word  i_in_word = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    // Character words still owed by the block, oldest first.
    t_out_word pending_chars[$];

    int unsigned numbers_sent = 0;
    int unsigned chars_checked = 0;
    int unsigned error_words_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Sender pacing. With gaps enabled, the sender offers bursts of words and
    // then drops valid for a random number of cycles.
    bit          tx_gaps = 1'b0;
    int unsigned burst_left = 0;

    // Receiver pacing. The stall style changes every so often. A test can ask
    // for one long hold-off, which this process counts down by itself.
    bit          rx_hold_req = 1'b0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;
    int unsigned rx_style = 0;
    int unsigned rx_period = 0;

    integer_to_ascii_formatter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Behavioral formatter. It builds the text least significant character
    // first, exactly as the block fills its buffer, and then queues it in
    // reverse so that the leftmost character is expected first.
    function automatic void format_number(input t_in_word w);
        logic [7:0]  text [0:DEFAULT_MAX_WIDTH-1];
        int unsigned len;
        int unsigned radix;
        int unsigned span;
        logic [31:0] mag;
        logic [7:0]  digit;
        logic        neg;
        logic        pre;
        t_out_word   c;
        len = 0;
        neg = 1'b0;
        pre = w.alt_prefix;
        mag = w.value;
        span = w.field_width;
        // A pointer with zero padding, or a mode with no conversion, gives one
        // error word and no text.
        if (w.mode > MODE_SDEC || (w.mode == MODE_PTR && w.zero_fill)) begin
            c.character = 8'h00;
            c.last = 1'b1;
            c.error = 1'b1;
            pending_chars.push_back(c);
            return;
        end
        case (w.mode)
            MODE_BIN: begin
                radix = 2;
            end
            MODE_HEX, MODE_PTR: begin
                radix = 16;
            end
            default: begin
                radix = 10;
            end
        endcase
        // A pointer always carries its 0x prefix.
        if (w.mode == MODE_PTR) begin
            pre = 1'b1;
        end
        // The most negative value wraps to itself, and read as unsigned it is
        // exactly the magnitude 2^31 that has to be printed.
        if (w.mode == MODE_SDEC && mag[31]) begin
            neg = 1'b1;
            mag = -mag;
        end
        do begin
            digit = 8'(mag % radix);
            text[len] = (digit < 8'd10) ? CH_ZERO + digit : CH_LOW_A + digit - 8'd10;
            len++;
            mag = mag / radix;
        end while (mag != 0);
        if (span > DEFAULT_MAX_WIDTH) begin
            span = DEFAULT_MAX_WIDTH;
        end
        // Zero padding leaves room for the prefix and the sign. The room left
        // saturates at zero when the field is narrower than both. Since at
        // most 32 digits and a 64 character field are involved, the text
        // never outgrows the buffer.
        if (w.zero_fill) begin
            if (pre) begin
                span = (span >= 2) ? span - 2 : 0;
            end
            if (neg) begin
                span = (span >= 1) ? span - 1 : 0;
            end
            while (len < span) begin
                text[len] = CH_ZERO;
                len++;
            end
        end
        // Decimal gets a bare zero as its prefix, the others 0x or 0b.
        if (pre) begin
            if (radix == 16) begin
                text[len] = CH_LOW_X;
                len++;
            end else if (radix == 2) begin
                text[len] = CH_LOW_B;
                len++;
            end
            text[len] = CH_ZERO;
            len++;
        end
        if (neg) begin
            text[len] = CH_MINUS;
            len++;
        end
        // Leading spaces fill what is left. The width is only a minimum.
        while (len < span) begin
            text[len] = CH_SPACE;
            len++;
        end
        for (int k = int'(len) - 1; k >= 0; k--) begin
            c.character = text[k];
            c.last = (k == 0);
            c.error = 1'b0;
            pending_chars.push_back(c);
        end
    endfunction

    function automatic t_in_word make_word(input logic [2:0] mode, input logic [31:0] value,
                                           input logic zero_fill, input logic alt_prefix,
                                           input logic [7:0] field_width);
        t_in_word w;
        w.mode = mode;
        w.value = value;
        w.zero_fill = zero_fill;
        w.alt_prefix = alt_prefix;
        w.field_width = field_width;
        return w;
    endfunction

    // Random number word. The values lean toward the interesting corners:
    // small numbers, single bits, values near all ones and near the signed
    // limits. Most widths are narrow so that most texts stay short, and one
    // word in ten may ask for a width anywhere up to 255.
    function automatic t_in_word random_word();
        t_in_word w;
        case ($urandom_range(0, 4))
            0: begin
                w.value = $urandom_range(0, 255);
            end
            1: begin
                w.value = 32'h1 << $urandom_range(0, 31);
            end
            2: begin
                w.value = ~$urandom_range(0, 255);
            end
            3: begin
                w.value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                               : 32'h7fff_ffff - $urandom_range(0, 3);
            end
            default: begin
                w.value = $urandom;
            end
        endcase
        if ($urandom_range(0, 9) == 0) begin
            w.mode = 3'($urandom_range(MODE_SDEC + 3'd1, MODE_TOP));
        end else begin
            w.mode = 3'($urandom_range(MODE_BIN, MODE_SDEC));
        end
        w.zero_fill = 1'($urandom_range(0, 1));
        w.alt_prefix = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0: begin
                w.field_width = 8'($urandom_range(0, 255));
            end
            1, 2, 3: begin
                w.field_width = 8'($urandom_range(21, 70));
            end
            default: begin
                w.field_width = 8'($urandom_range(0, 20));
            end
        endcase
        return w;
    endfunction

    // Offers one number word and holds it until the block takes it. The task
    // is always entered right after a rising edge. Without gaps it returns at
    // the edge that accepted the word, so the next word can follow without a gap.
    task automatic send_number(input t_in_word w);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        format_number(w);
        numbers_sent++;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 160)
                                                  : $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Pointer with zero padding, then every unused mode.
    task automatic test_error_words();
        send_number(make_word(MODE_PTR, 32'h1234_5678, 1'b1, 1'b0, 8'd10));
        send_number(make_word(MODE_SDEC + 3'd1, 32'hffff_ffff, 1'b0, 1'b1, 8'd5));
        send_number(make_word(MODE_SDEC + 3'd2, 32'h0, 1'b1, 1'b1, 8'd255));
        send_number(make_word(MODE_TOP, 32'h8000_0000, 1'b0, 1'b0, 8'd0));
    endtask

    // Zero in binary and as a pointer, all ones in binary, hex, unsigned and signed decimal, and both signed limits.
    task automatic test_extremes();
        send_number(make_word(MODE_BIN, 32'h0, 1'b0, 1'b0, 8'd0));
        send_number(make_word(MODE_BIN, 32'hffff_ffff, 1'b0, 1'b0, 8'd0));
        send_number(make_word(MODE_HEX, 32'hffff_ffff, 1'b0, 1'b1, 8'd0));
        send_number(make_word(MODE_UDEC, 32'hffff_ffff, 1'b0, 1'b0, 8'd0));
        send_number(make_word(MODE_SDEC, 32'h8000_0000, 1'b0, 1'b0, 8'd0));
        send_number(make_word(MODE_SDEC, 32'h7fff_ffff, 1'b0, 1'b0, 8'd0));
        send_number(make_word(MODE_SDEC, 32'hffff_ffff, 1'b0, 1'b0, 8'd0));
        send_number(make_word(MODE_PTR, 32'h0, 1'b0, 1'b0, 8'd0));
    endtask

    // Prefix, sign and padding interplay: a field too narrow for the prefix
    // and sign, the bare decimal zero, capped widths and text wider than the
    // requested field.
    task automatic test_prefix_and_padding();
        send_number(make_word(MODE_SDEC, 32'hffff_fffb, 1'b1, 1'b1, 8'd0));
        send_number(make_word(MODE_HEX, 32'h0000_001a, 1'b1, 1'b1, 8'd1));
        send_number(make_word(MODE_UDEC, 32'd907, 1'b1, 1'b1, 8'd10));
        send_number(make_word(MODE_BIN, 32'h0000_00a5, 1'b1, 1'b1, 8'd255));
        send_number(make_word(MODE_HEX, 32'hdead_beef, 1'b0, 1'b0, 8'd255));
        send_number(make_word(MODE_SDEC, 32'hffff_ff00, 1'b1, 1'b0, 8'd255));
        send_number(make_word(MODE_UDEC, 32'd12345, 1'b0, 1'b0, 8'd3));
        send_number(make_word(MODE_SDEC, 32'hffff_ffd6, 1'b0, 1'b1, 8'd12));
        send_number(make_word(MODE_BIN, 32'd5, 1'b0, 1'b1, 8'd8));
    endtask

    // The receiver stops taking characters for a long stretch while the
    // sender keeps offering numbers back to back, so the block has to stall
    // its input until the output drains.
    task automatic test_output_hold_off();
        tx_gaps = 1'b0;
        rx_hold_req = 1'b1;
        repeat (8) send_number(random_word());
    endtask

    // Bulk random numbers. The sender switches between back to back words
    // and bursts with gaps every fifty numbers.
    task automatic test_random_formats();
        for (int n = 0; n < 400; n++) begin
            if (n % 50 == 0) begin
                tx_gaps = ($urandom_range(0, 2) != 0);
            end
            send_number(random_word());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_error_words();
        test_extremes();
        test_prefix_and_padding();
        test_output_hold_off();
        test_random_formats();
        // The last word has been taken by this edge, so valid can drop here.
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        // Give a stray extra word time to show up.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d numbers in all five modes and the unused ones; %0d characters",
                 numbers_sent, chars_checked);
        $display("and %0d error words came back, under random stalls and one long hold-off.",
                 error_words_seen);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver. Style 0 never stalls, style 1 stalls often and briefly and
    // style 2 stalls rarely but for longer. The long hold-off asked for by a
    // test overrides all of them.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            case (rx_style)
                1: begin
                    if ($urandom_range(0, 3) == 0) begin
                        stall_left = $urandom_range(1, 3);
                    end
                end
                2: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 20);
                    end
                end
                default: begin
                end
            endcase
        end
        rx_period++;
        if (rx_period == 150) begin
            rx_period = 0;
            rx_style = $urandom_range(0, 2);
        end
    end

    // Output monitor. Values are read at the edge, before the block or the
    // receiver update anything, so each accepted word is seen exactly once.
    always @(posedge i_clk) begin : check_chars
        t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            if (o_out_word.error === 1'b1) begin
                error_words_seen++;
            end
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected output word, character %h last %b error %b",
                         $time, o_out_word.character, o_out_word.last, o_out_word.error);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (o_out_word.character !== want.character) begin
                    $display("%0t: character mismatch, expected %h got %h",
                             $time, want.character, o_out_word.character);
                    mismatch_count++;
                end
                if (o_out_word.last !== want.last) begin
                    $display("%0t: last mismatch, expected %b got %b",
                             $time, want.last, o_out_word.last);
                    mismatch_count++;
                end
                if (o_out_word.error !== want.error) begin
                    $display("%0t: error mismatch, expected %b got %b",
                             $time, want.error, o_out_word.error);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d characters outstanding.",
                     cycle_count, pending_chars.size());
            $display("FAILURE");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ integer_to_ascii_formatter.f @@
rtl/itoa_pkg.sv
rtl/integer_to_ascii_formatter.sv
tb/sv/tb_top.sv
